/* src/prrq_pkg.sv */
// prrq_pkg: shared constants, operation and status codes of the run-queue scheduler
// no dependencies; used by priority_round_robin_run_queue_unit
package prrq_pkg;

	localparam int MAX_THREADS     = 16;
	localparam int PRIORITY_LEVELS = 3;

	localparam int OP_W     = 3;
	localparam int TID_W    = 4;
	localparam int PRIO_W   = 2;
	localparam int STATUS_W = 2;
	localparam int TDATA_W  = 16;

	typedef enum logic [OP_W-1:0] {
		OP_PREEMPT = 3'd0,
		OP_YIELD   = 3'd1,
		OP_RESUME  = 3'd2,
		OP_EXIT    = 3'd3,
		OP_SETPRI  = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_BAD_PRIO = 2'd1,
		ST_BUSY     = 2'd2
	} status_t;

	// thread number reduced by the thread count, narrow input so a short subtract chain
	function automatic logic [TID_W-1:0] tid_reduce(input logic [TID_W-1:0] v, input int m);
		logic [TID_W:0] r;
		r = {1'b0, v};
		for (int i = 0; i < 8; i++) begin
			if (int'(r) >= m) begin
				r = r - (TID_W+1)'(m);
			end
		end
		return r[TID_W-1:0];
	endfunction

endpackage

/* src/priority_round_robin_run_queue_unit.sv */
// priority_round_robin_run_queue_unit: multilevel priority round-robin run queue
// depends on prrq_pkg; holds the queue store and priority table memories
//
// One scheduler operation per input transfer, one result transfer per operation. The unit
// works on one operation at a time and is not ready meanwhile. It reads the thread's level,
// then the running thread's level, from the priority table and executes; a preempt, yield or
// exit with a thread running then dispatches the head of the most urgent non-empty queue, if
// any. The result register is loaded once the sink has taken any earlier result; the input is
// ready again in the cycle after. The order is set by the single read port of the priority
// table (two levels are read one after the other) and the single port of the queue store (one
// push write, then one registered head read for a dispatch). No clearing pass: table entries
// never written read as level zero through per-entry valid flags.
module priority_round_robin_run_queue_unit #(
	parameter int MaxThreads     = prrq_pkg::MAX_THREADS,
	parameter int PriorityLevels = prrq_pkg::PRIORITY_LEVELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// opcode[2:0], thread_id[6:3], priority_req[8:7], zero fill
	input  logic [prrq_pkg::TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// running_thread[3:0], running_valid[4], switched[5], preempt_request[6], status[8:7]
	output logic [prrq_pkg::TDATA_W-1:0] m_tdata
);

	localparam int TW = (MaxThreads > 1) ? $clog2(MaxThreads) : 1;
	localparam int CW = $clog2(MaxThreads + 1);
	localparam int LW = (PriorityLevels > 1) ? $clog2(PriorityLevels) : 1;
	localparam int AW = $clog2(MaxThreads * PriorityLevels);
	localparam int PW = prrq_pkg::PRIO_W;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD1  = 7'b0000010,
		S_RD2  = 7'b0000100,
		S_EXEC = 7'b0001000,
		S_SEL  = 7'b0010000,
		S_DISP = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [prrq_pkg::OP_W-1:0] op_q;
	logic [TW-1:0] tid_q;
	logic [PW-1:0] preq_q;
	logic old_on_q;
	logic [TW-1:0] old_id_q;
	logic preempt_q;
	prrq_pkg::status_t status_q;

	logic [TW-1:0] run_id_q;
	logic run_on_q;
	logic [MaxThreads-1:0] marks_q;
	logic [TW-1:0] head_q [PriorityLevels];
	logic [CW-1:0] cnt_q [PriorityLevels];
	logic [LW-1:0] lvl_t_q;
	logic [LW-1:0] lvl_r_q;
	logic [LW-1:0] sel_q;

	// priority table memory with per-entry valid flags
	logic [PW-1:0] pt_mem [MaxThreads];
	logic [MaxThreads-1:0] pt_vld_q;
	logic [PW-1:0] pt_rd_q;
	logic pt_rv_q;
	logic [TW-1:0] pt_addr;
	logic pt_we;

	// queue store memory, one region of MaxThreads slots per level
	logic [TW-1:0] st_mem [MaxThreads*PriorityLevels];
	logic [TW-1:0] st_rd_q;
	logic [AW-1:0] st_addr;
	logic st_we;

	logic [TW-1:0] tid_in;
	logic [LW-1:0] rd_lvl;
	logic [LW-1:0] enc;
	logic any_lvl;
	logic [LW-1:0] qi;
	logic [TW-1:0] q_head;
	logic [CW-1:0] q_cnt;
	logic q_full;
	logic [TW-1:0] head_dec;
	logic [TW-1:0] head_inc;
	logic [CW:0] tail_sum;
	logic [TW-1:0] tail;
	logic [TW-1:0] push_slot;
	logic [TW-1:0] push_id;
	logic resume_bad;
	logic do_push;
	logic [prrq_pkg::TDATA_W-1:0] out_q;
	logic m_tvalid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	assign tid_in = TW'(prrq_pkg::tid_reduce(s_tdata[6:3], MaxThreads));

	// level from the table read, clamped to the least urgent queue
	always_comb begin
		logic [PW-1:0] d;
		d = pt_rv_q ? pt_rd_q : '0;
		if (int'(d) >= PriorityLevels) begin
			rd_lvl = LW'(PriorityLevels - 1);
		end else begin
			rd_lvl = LW'(d);
		end
	end

	// most urgent non-empty level
	always_comb begin
		any_lvl = 1'b0;
		enc = '0;
		for (int i = PriorityLevels - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				any_lvl = 1'b1;
				enc = LW'(i);
			end
		end
	end

	always_comb begin
		case (state_q)
			S_EXEC: qi = (op_q == prrq_pkg::OP_RESUME) ? lvl_t_q : lvl_r_q;
			S_DISP: qi = sel_q;
			default: qi = enc;
		endcase
	end

	assign q_head = head_q[qi];
	assign q_cnt = cnt_q[qi];
	assign q_full = (int'(q_cnt) >= MaxThreads);
	assign head_dec = (q_head == '0) ? TW'(MaxThreads - 1) : q_head - TW'(1);
	assign head_inc = (q_head == TW'(MaxThreads - 1)) ? '0 : q_head + TW'(1);
	assign tail_sum = (CW+1)'(q_head) + (CW+1)'(q_cnt);
	assign tail = (int'(tail_sum) >= MaxThreads) ? TW'(tail_sum - (CW+1)'(MaxThreads))
		: TW'(tail_sum);
	assign push_slot = (op_q == prrq_pkg::OP_PREEMPT) ? head_dec : tail;
	assign push_id = (op_q == prrq_pkg::OP_RESUME) ? tid_q : run_id_q;
	assign resume_bad = marks_q[tid_q] || (run_on_q && run_id_q == tid_q);

	always_comb begin
		do_push = 1'b0;
		if (state_q == S_EXEC && run_on_q && !q_full) begin
			case (op_q)
				prrq_pkg::OP_PREEMPT, prrq_pkg::OP_YIELD: do_push = 1'b1;
				prrq_pkg::OP_RESUME: do_push = !resume_bad;
				default: do_push = 1'b0;
			endcase
		end
	end

	assign st_we = do_push;
	assign st_addr = AW'(AW'(qi) * AW'(MaxThreads))
		+ AW'((state_q == S_EXEC) ? push_slot : q_head);

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_addr] <= push_id;
		end
		st_rd_q <= st_mem[st_addr];
	end

	always_comb begin
		case (state_q)
			S_IDLE: pt_addr = tid_in;
			S_RD1: pt_addr = run_id_q;
			default: pt_addr = tid_q;
		endcase
	end

	assign pt_we = (state_q == S_EXEC) && (op_q == prrq_pkg::OP_SETPRI)
		&& (int'(preq_q) < PriorityLevels);

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[pt_addr] <= preq_q;
		end
		pt_rd_q <= pt_mem[pt_addr];
		pt_rv_q <= pt_vld_q[pt_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			op_q <= s_tdata[2:0];
			tid_q <= tid_in;
			preq_q <= s_tdata[8:7];
		end
		if (state_q == S_OUT && (!m_tvalid_q || m_tready)) begin
			out_q <= prrq_pkg::TDATA_W'({status_q, preempt_q,
				(old_on_q != run_on_q) || (run_on_q && old_id_q != run_id_q),
				run_on_q, run_on_q ? 4'(run_id_q) : 4'd0});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			run_id_q <= '0;
			run_on_q <= 1'b1;
			marks_q <= '0;
			pt_vld_q <= '0;
			m_tvalid_q <= 1'b0;
			old_on_q <= 1'b0;
			old_id_q <= '0;
			preempt_q <= 1'b0;
			status_q <= prrq_pkg::ST_OK;
			lvl_t_q <= '0;
			lvl_r_q <= '0;
			sel_q <= '0;
			for (int i = 0; i < PriorityLevels; i++) begin
				head_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else begin
			if (state_q == S_OUT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (do_push) begin
				if (op_q == prrq_pkg::OP_PREEMPT) begin
					head_q[qi] <= head_dec;
				end
				cnt_q[qi] <= q_cnt + CW'(1);
				marks_q[push_id] <= 1'b1;
			end
			if (pt_we) begin
				pt_vld_q[pt_addr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						old_on_q <= run_on_q;
						old_id_q <= run_id_q;
						preempt_q <= 1'b0;
						status_q <= prrq_pkg::ST_OK;
						state_q <= S_RD1;
					end
				end
				S_RD1: begin
					lvl_t_q <= rd_lvl;
					state_q <= S_RD2;
				end
				S_RD2: begin
					lvl_r_q <= rd_lvl;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					case (op_q)
						prrq_pkg::OP_PREEMPT, prrq_pkg::OP_YIELD, prrq_pkg::OP_EXIT: begin
							state_q <= run_on_q ? S_SEL : S_OUT;
						end
						prrq_pkg::OP_RESUME: begin
							state_q <= S_OUT;
							if (resume_bad) begin
								status_q <= prrq_pkg::ST_BUSY;
							end else if (!run_on_q) begin
								run_id_q <= tid_q;
								run_on_q <= 1'b1;
							end else begin
								preempt_q <= (lvl_r_q > lvl_t_q);
							end
						end
						prrq_pkg::OP_SETPRI: begin
							state_q <= S_OUT;
							if (!pt_we) begin
								status_q <= prrq_pkg::ST_BAD_PRIO;
							end
						end
						default: begin
							state_q <= S_OUT;
						end
					endcase
				end
				S_SEL: begin
					if (any_lvl) begin
						sel_q <= enc;
						state_q <= S_DISP;
					end else begin
						run_on_q <= 1'b0;
						state_q <= S_OUT;
					end
				end
				S_DISP: begin
					head_q[qi] <= head_inc;
					cnt_q[qi] <= q_cnt - CW'(1);
					marks_q[st_rd_q] <= 1'b0;
					run_id_q <= st_rd_q;
					run_on_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a dispatch always leaves a thread running
	a_disp_runs: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DISP |=> run_on_q)
		else $error("dispatch left the unit idle");

	// the running thread is never also waiting in a queue between operations
	a_run_not_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && run_on_q) |-> !marks_q[run_id_q])
		else $error("running thread also marked as queued");

	// an accepted transfer starts the table reads
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> state_q == S_RD1)
		else $error("accepted transfer did not start the sequence");

	// a preemption request only comes with a successful resume
	a_preempt_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[6]) |-> m_tdata[8:7] == prrq_pkg::ST_OK)
		else $error("preemption request with error status");

endmodule
